// ===== sv/g2l_pkg.sv =====
// Shared types and constants of the global to local coordinate mapper.
package g2l_pkg;

   localparam int COL_FIELD_W = 8;
   localparam int POS_W       = 40;
   localparam int SEQ_FIELD_W = 8;
   localparam int PACK_W      = 48;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_MAP    = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_COL   = 3'd1,
      STAT_BAD_COORD = 3'd2,
      STAT_BAD_SEQ   = 3'd3,
      STAT_ZERO      = 3'd4,
      STAT_FULL      = 3'd5,
      STAT_OVERFLOW  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_TOTAL,
      S_APPEND,
      S_MAP_CHECK,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_LOC,
      S_MULT,
      S_Q_RD_START,
      S_Q_SUB,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [COL_FIELD_W-1:0] column;
      logic [POS_W-1:0]       coordinate;
      logic [POS_W-1:0]       kmer_count;
      logic [SEQ_FIELD_W-1:0] sequence_index;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [SEQ_FIELD_W-1:0] found_sequence;
      logic [POS_W-1:0]       local_offset;
      logic [PACK_W-1:0]      packed_coordinate;
      logic [POS_W-1:0]       sequence_count_out;
   } rsp_type;

endpackage

// ===== sv/g2l_req_if.sv =====
// Request channel interface: valid, ready and the request payload.
interface g2l_req_if;
   import g2l_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/g2l_rsp_if.sv =====
// Response channel interface: valid, ready and the response payload.
interface g2l_rsp_if;
   import g2l_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/global_to_local_coord_mapper_core.sv =====
// One request at a time; the next is taken in the cycle after the last result is registered.
// The map cost is set by the binary search: one end-memory read and one shared compare a step.
// A result waits in the output register while the next request is taken.
// Synchronous reset clears the control state and every column fill;
// the sequence end memory is not cleared and needs no clearing pass.
module global_to_local_coord_mapper_core #(
   parameter int COLUMN_COUNT  = 16,
   parameter int MAX_SEQUENCES = 256,
   parameter int COORD_BITS    = 40
) (
   input  logic          clock,
   input  logic          reset,
   g2l_req_if.sink       req_chan,
   g2l_rsp_if.source     rsp_chan
);
   import g2l_pkg::*;

   localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
   localparam int SEQ_W  = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
   localparam int FILL_W = $clog2(MAX_SEQUENCES + 1);
   localparam int ADDR_W = COL_W + SEQ_W;
   localparam int AW     = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
   localparam int MUL_W  = POS_W + FILL_W;
   localparam int SUM_W  = MUL_W + 1;
   localparam logic [COL_FIELD_W:0] COL_LIMIT = (COL_FIELD_W + 1)'(COLUMN_COUNT);
   localparam logic [FILL_W-1:0]    FILL_MAX  = FILL_W'(MAX_SEQUENCES);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [COORD_BITS-1:0] total_ff, total_in;
   logic [COORD_BITS-1:0] end_ff, end_in;
   logic [SEQ_W-1:0]      lo_ff, lo_in;
   logic [SEQ_W-1:0]      hi_ff, hi_in;
   logic [SEQ_W-1:0]      mid_ff, mid_in;
   logic [POS_W-1:0]      local_ff, local_in;

   logic [FILL_W-1:0] column_fill_ff [COLUMN_COUNT];
   logic [FILL_W-1:0] fill_wr_in;
   logic              fill_we;

   logic [COORD_BITS-1:0] end_mem [2**ADDR_W];
   logic [COORD_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     mem_addr;
   logic                  mem_we;
   logic [COORD_BITS-1:0] mem_wdata;

   logic [AW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [AW:0]   alu_res;
   logic          alu_borrow;
   logic          alu_ovf;

   logic [COL_W-1:0] col_idx;
   logic             col_ok;
   logic [FILL_W-1:0] fill_rd;
   logic [FILL_W-1:0] fill_rd_m1;
   logic [SEQ_W:0]    mid_sum;
   logic [SEQ_W-1:0]  mid_calc;
   logic [SEQ_W-1:0]  sidx_seq;
   logic              sidx_bad;
   logic [MUL_W-1:0]  mult_res;
   logic [SUM_W-1:0]  packed_sum;

   function automatic logic [SEQ_W-1:0] fill_rd_m1_hold(input logic [FILL_W-1:0] f);
      logic [FILL_W-1:0] d;
      d = f - FILL_W'(1);
      return d[SEQ_W-1:0];
   endfunction

   assign col_idx    = req_ff.column[COL_W-1:0];
   assign col_ok     = {1'b0, req_ff.column} < COL_LIMIT;
   assign fill_rd    = column_fill_ff[col_idx];
   assign fill_rd_m1 = fill_rd - FILL_W'(1);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc   = mid_sum[SEQ_W:1];
   assign sidx_seq   = req_ff.sequence_index[SEQ_W-1:0];
   assign sidx_bad   = {1'b0, req_ff.sequence_index} >= (SEQ_FIELD_W + 1)'(fill_ff);
   assign fill_wr_in = fill_ff + FILL_W'(1);

   assign mult_res   = local_ff * fill_ff;
   assign packed_sum = SUM_W'(mult_res) + SUM_W'(lo_ff);

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         S_APPEND: begin
            alu_a   = AW'(total_ff);
            alu_b   = AW'(req_ff.kmer_count);
            alu_sub = 1'b0;
         end
         S_MAP_CHECK: begin
            alu_a = AW'(req_ff.coordinate);
            alu_b = AW'(total_ff);
         end
         S_SRCH_CMP: begin
            alu_a = AW'(req_ff.coordinate);
            alu_b = AW'(rd_data_ff);
         end
         S_LOC: begin
            alu_a = AW'(req_ff.coordinate);
            alu_b = (lo_ff != '0) ? AW'(rd_data_ff) : '0;
         end
         S_Q_SUB: begin
            alu_a = AW'(end_ff);
            alu_b = (req_ff.sequence_index != '0) ? AW'(rd_data_ff) : '0;
         end
         default: begin
            alu_sub = 1'b1;
         end
      endcase
   end

   assign alu_res    = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(AW + 1){alu_sub}})
                       + (AW + 1)'(alu_sub);
   assign alu_borrow = alu_res[AW];
   assign alu_ovf    = |alu_res[AW:COORD_BITS];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      fill_in      = fill_ff;
      total_in     = total_ff;
      end_in       = end_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      local_in     = local_ff;
      mem_addr     = {col_idx, SEQ_W'(0)};
      mem_we       = 1'b0;
      mem_wdata    = alu_res[COORD_BITS-1:0];
      fill_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               res_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            fill_in  = fill_rd;
            mem_addr = {col_idx, fill_rd_m1[SEQ_W-1:0]};
            if (!(req_ff.operation == OP_APPEND || req_ff.operation == OP_MAP ||
                  req_ff.operation == OP_QUERY)) begin
               state_in = S_DONE;
            end else if (!col_ok) begin
               res_in.status = STAT_BAD_COL;
               state_in      = S_DONE;
            end else begin
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            total_in = (fill_ff != '0) ? rd_data_ff : '0;
            case (req_ff.operation)
               OP_APPEND: state_in = S_APPEND;
               OP_MAP:    state_in = S_MAP_CHECK;
               default: begin
                  if (sidx_bad) begin
                     res_in.status = STAT_BAD_SEQ;
                     state_in      = S_DONE;
                  end else begin
                     mem_addr = {col_idx, sidx_seq};
                     state_in = S_Q_RD_START;
                  end
               end
            endcase
         end
         S_APPEND: begin
            if (req_ff.kmer_count == '0) begin
               res_in.status = STAT_ZERO;
            end else if (fill_ff >= FILL_MAX) begin
               res_in.status = STAT_FULL;
            end else if (alu_ovf) begin
               res_in.status = STAT_OVERFLOW;
            end else begin
               mem_we   = 1'b1;
               mem_addr = {col_idx, fill_ff[SEQ_W-1:0]};
               fill_we  = 1'b1;
            end
            state_in = S_DONE;
         end
         S_MAP_CHECK: begin
            if (!alu_borrow) begin
               res_in.status = STAT_BAD_COORD;
               state_in      = S_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = fill_rd_m1_hold(fill_ff);
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               mem_addr = {col_idx, mid_calc};
               state_in = S_SRCH_CMP;
            end else begin
               mem_addr = {col_idx, lo_ff - SEQ_W'(1)};
               state_in = S_LOC;
            end
         end
         S_SRCH_CMP: begin
            if (alu_borrow) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + SEQ_W'(1);
            end
            state_in = S_SRCH_RD;
         end
         S_LOC: begin
            local_in = alu_res[POS_W-1:0];
            state_in = S_MULT;
         end
         S_MULT: begin
            res_in.found_sequence    = SEQ_FIELD_W'(lo_ff);
            res_in.local_offset      = local_ff;
            res_in.packed_coordinate = PACK_W'(packed_sum);
            state_in                 = S_DONE;
         end
         S_Q_RD_START: begin
            end_in   = rd_data_ff;
            mem_addr = {col_idx, sidx_seq - SEQ_W'(1)};
            state_in = S_Q_SUB;
         end
         S_Q_SUB: begin
            res_in.sequence_count_out = alu_res[POS_W-1:0];
            state_in                  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      fill_ff  <= fill_in;
      total_ff <= total_in;
      end_ff   <= end_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      local_ff <= local_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMN_COUNT; i++) begin
            column_fill_ff[i] <= '0;
         end
      end else if (fill_we) begin
         column_fill_ff[col_idx] <= fill_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         end_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= end_mem[mem_addr];
   end

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

// ===== sv/g2l_checker.sv =====
// Port-level checks of the coordinate mapper and their binding to the mapper core.
module g2l_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input g2l_pkg::status_type           status,
   input logic [g2l_pkg::SEQ_FIELD_W-1:0] found_sequence,
   input logic [g2l_pkg::POS_W-1:0]     local_offset,
   input logic [g2l_pkg::PACK_W-1:0]    packed_coordinate,
   input logic [g2l_pkg::POS_W-1:0]     sequence_count_out
);
   import g2l_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != STAT_OK) |->
         (found_sequence == '0) && (local_offset == '0) &&
         (packed_coordinate == '0) && (sequence_count_out == '0))
      else $error("error response carries nonzero result fields");

   a_query_excludes_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (sequence_count_out != '0) |->
         (found_sequence == '0) && (local_offset == '0) && (packed_coordinate == '0))
      else $error("count query response carries map fields");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind global_to_local_coord_mapper_core g2l_checker u_g2l_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .status             (rsp_chan.payload.status),
   .found_sequence     (rsp_chan.payload.found_sequence),
   .local_offset       (rsp_chan.payload.local_offset),
   .packed_coordinate  (rsp_chan.payload.packed_coordinate),
   .sequence_count_out (rsp_chan.payload.sequence_count_out)
);

// ===== verif/global_to_local_coord_mapper_core_tb.sv =====
// Testbench of the coordinate mapper core: directed and random requests checked by a scoreboard.
module global_to_local_coord_mapper_core_tb;
   import g2l_pkg::*;

   localparam int NUM_COLS       = 16;
   localparam int MAX_SEQ        = 256;
   localparam int COORD_W        = 40;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [POS_W:0] COORD_LIMIT = (41'd1 << COORD_W) - 41'd1;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int RANDOM_ITEMS_A = 600;
   localparam int RANDOM_ITEMS_B = 800;
   localparam int LONG_HOLD      = 300;
   localparam int IDLE_LIMIT     = 4000;
   localparam int TAIL_CYCLES    = 40;

   class mapper_scoreboard;
      int unsigned fill [NUM_COLS];
      logic [POS_W-1:0] seq_end [NUM_COLS][MAX_SEQ];
      rsp_type pending_results [$];
      int failures;

      function new();
         foreach (fill[c]) fill[c] = 0;
         failures = 0;
      endfunction

      function logic [POS_W-1:0] column_total(int col);
         return (fill[col] == 0) ? '0 : seq_end[col][fill[col] - 1];
      endfunction

      function logic [POS_W-1:0] seq_start(int col, int s);
         return (s == 0) ? '0 : seq_end[col][s - 1];
      endfunction

      function rsp_type resolve_request(req_type r);
         rsp_type res;
         logic [POS_W:0] new_end;
         logic [63:0] product;
         logic [POS_W-1:0] total;
         int col, lo, hi, mid;
         res = '0;
         col = int'(r.column);
         if (r.operation == OP_UNUSED) return res;
         if (col >= NUM_COLS) begin
            res.status = STAT_BAD_COL;
            return res;
         end
         total = column_total(col);
         case (r.operation)
            OP_APPEND: begin
               new_end = {1'b0, total} + {1'b0, r.kmer_count};
               if (r.kmer_count == '0) res.status = STAT_ZERO;
               else if (fill[col] >= MAX_SEQ) res.status = STAT_FULL;
               else if (new_end > COORD_LIMIT) res.status = STAT_OVERFLOW;
               else begin
                  seq_end[col][fill[col]] = new_end[POS_W-1:0];
                  fill[col]++;
               end
            end
            OP_MAP: begin
               if (r.coordinate >= total) res.status = STAT_BAD_COORD;
               else begin
                  lo = 0;
                  hi = fill[col] - 1;
                  while (lo < hi) begin
                     mid = lo + (hi - lo) / 2;
                     if (seq_end[col][mid] > r.coordinate) hi = mid;
                     else lo = mid + 1;
                  end
                  res.found_sequence = lo[SEQ_FIELD_W-1:0];
                  res.local_offset = r.coordinate - seq_start(col, lo);
                  product = 64'(res.local_offset) * 64'(fill[col]) + 64'(lo);
                  res.packed_coordinate = product[PACK_W-1:0];
               end
            end
            OP_QUERY: begin
               if (32'(r.sequence_index) >= fill[col]) res.status = STAT_BAD_SEQ;
               else res.sequence_count_out = seq_end[col][r.sequence_index]
                                             - seq_start(col, int'(r.sequence_index));
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         pending_results.push_back(resolve_request(r));
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding, status %0d", got.status);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("found_sequence", 64'(want.found_sequence),
                       64'(got.found_sequence));
         compare_field("local_offset", 64'(want.local_offset), 64'(got.local_offset));
         compare_field("packed_coordinate", 64'(want.packed_coordinate),
                       64'(got.packed_coordinate));
         compare_field("sequence_count_out", 64'(want.sequence_count_out),
                       64'(got.sequence_count_out));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   hold_sink;
   bit   sender_steady;
   mapper_scoreboard sb;

   g2l_req_if req_chan ();
   g2l_rsp_if rsp_chan ();

   global_to_local_coord_mapper_core #(
      .COLUMN_COUNT  (NUM_COLS),
      .MAX_SEQUENCES (MAX_SEQ),
      .COORD_BITS    (COORD_W)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [POS_W-1:0] rand_pos();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] rand_below(logic [POS_W-1:0] n);
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      w = w % 64'(n);
      return w[POS_W-1:0];
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type blank_req(logic [1:0] op, int col);
      req_type r;
      r.operation      = op;
      r.column         = col[COL_FIELD_W-1:0];
      r.coordinate     = rand_pos();
      r.kmer_count     = rand_pos();
      r.sequence_index = SEQ_FIELD_W'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic send(req_type r);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(r);
      @(negedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_append(int col, logic [POS_W-1:0] count);
      req_type r;
      r = blank_req(OP_APPEND, col);
      r.kmer_count = count;
      send(r);
   endtask

   task automatic send_map(int col, logic [POS_W-1:0] coord);
      req_type r;
      r = blank_req(OP_MAP, col);
      r.coordinate = coord;
      send(r);
   endtask

   task automatic send_query(int col, logic [SEQ_FIELD_W-1:0] sidx);
      req_type r;
      r = blank_req(OP_QUERY, col);
      r.sequence_index = sidx;
      send(r);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(int focus);
      int col, roll, f, s;
      logic [POS_W-1:0] total, start, stop, count, coord;
      logic [SEQ_FIELD_W-1:0] sidx;
      req_type r;
      col = (focus >= 0 && $urandom_range(0, 1) == 1) ? focus
            : int'($urandom_range(0, NUM_COLS - 1));
      f = sb.fill[col];
      total = sb.column_total(col);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) count = '0;
         else if (roll < 9) count = rand_pos();
         else if (roll < 15) count = rand_below(40'h10_0000_0000) + 40'd1;
         else count = POS_W'($urandom_range(1, 2000));
         send_append(col, count);
      end else if (roll < 70) begin
         if (f == 0) coord = ($urandom_range(0, 1) == 1) ? rand_pos() : rand_below(40'd1000);
         else begin
            s = $urandom_range(0, f - 1);
            start = sb.seq_start(col, s);
            stop = sb.seq_end[col][s];
            case ($urandom_range(0, 7))
               0, 1:    coord = start;
               2, 3:    coord = stop - 40'd1;
               4, 5:    coord = start + rand_below(stop - start);
               6:       coord = total + rand_below(40'd4);
               default: coord = rand_pos();
            endcase
         end
         send_map(col, coord);
      end else if (roll < 90) begin
         if (f > 0 && $urandom_range(0, 4) != 0) sidx = SEQ_FIELD_W'($urandom_range(0, f - 1));
         else if ($urandom_range(0, 1) == 1) sidx = f[SEQ_FIELD_W-1:0];
         else sidx = SEQ_FIELD_W'($urandom_range(0, 255));
         send_query(col, sidx);
      end else begin
         r.operation      = 2'($urandom_range(0, 3));
         r.column         = COL_FIELD_W'($urandom_range(0, 255));
         r.coordinate     = rand_pos();
         r.kmer_count     = rand_pos();
         r.sequence_index = SEQ_FIELD_W'($urandom_range(0, 255));
         send(r);
      end
   endtask

   task automatic fill_column(int col);
      while (sb.fill[col] < MAX_SEQ && sb.column_total(col) < POS_MAX - 40'd64)
         send_append(col, POS_W'($urandom_range(1, 64)));
      send_append(col, 40'd1);
      send_append(col, '0);
      send_append(col, POS_MAX);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_response(rsp_chan.payload);
   end

   initial begin : response_sink
      int stall, mode_left, gap;
      bit steady;
      stall = 0;
      mode_left = 0;
      steady = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_sink) begin
            hold_sink = 1'b0;
            stall = LONG_HOLD;
         end
         if (mode_left == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 150);
         end
         mode_left--;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            gap = steady ? 0 : pick_gap();
            if (gap == 0) rsp_chan.ready <= 1'b1;
            else begin
               rsp_chan.ready <= 1'b0;
               stall = gap - 1;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int col, c;
      req_type r;
      sb = new();
      reset = 1'b1;
      hold_sink = 1'b0;
      sender_steady = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_append(0, 40'd1);
      send_append(0, POS_MAX);
      send_append(0, '0);
      send_append(255, 40'd5);
      send_append(NUM_COLS, 40'd5);
      send_append(200, '0);
      send_map(NUM_COLS, 40'd0);
      send_query(255, 8'd0);
      r = blank_req(OP_UNUSED, 0);
      send(r);
      r = blank_req(OP_UNUSED, 255);
      send(r);
      send_append(1, POS_MAX);
      send_append(1, 40'd1);
      send_map(1, POS_MAX - 40'd1);
      send_map(1, POS_MAX);
      send_map(5, 40'd0);
      send_query(5, 8'd0);
      send_append(0, 40'd2);
      send_append(NUM_COLS - 1, 40'd4);
      send_append(0, 40'd4);
      send_map(0, 40'd1);
      send_map(0, 40'd6);
      send_map(0, 40'd7);
      send_query(0, 8'd2);
      send_query(0, 8'd3);
      send_query(0, 8'd255);

      repeat (RANDOM_ITEMS_A) begin
         if ($urandom_range(0, 49) == 0) sender_steady = ~sender_steady;
         send_random(-1);
      end
      sender_steady = 1'b0;
      wait_drained();

      // fill the column from 2 up with the least total to capacity for deep searches
      col = 2;
      for (c = 3; c < NUM_COLS; c++)
         if (sb.column_total(c) < sb.column_total(col)) col = c;
      fill_column(col);

      // stall the sink while requests keep coming
      hold_sink = 1'b1;
      sender_steady = 1'b1;
      repeat (20) send_random(col);
      sender_steady = 1'b0;
      repeat (RANDOM_ITEMS_B / 2) begin
         if ($urandom_range(0, 49) == 0) sender_steady = ~sender_steady;
         send_random(col);
      end
      sender_steady = 1'b0;
      wait_drained();
      repeat (RANDOM_ITEMS_B / 2) begin
         if ($urandom_range(0, 49) == 0) sender_steady = ~sender_steady;
         send_random(($urandom_range(0, 1) == 1) ? col : -1);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d responses never arrived", sb.pending_results.size());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
